// File: design/crtl_pkg.sv
// code range table lookup: shared field widths, action and status codes, fsm states
// no dependencies
`timescale 1ns / 1ps

package crtl_pkg;

	localparam int unsigned ACTION_W = 2;
	localparam int unsigned CODE_W   = 21;
	localparam int unsigned BASE_W   = 24;
	localparam int unsigned GLYPH_W  = 25;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned BOUND_W  = 2 * CODE_W;

	// action codes of an input item
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

	// status codes of a result item
	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH,
		ST_HOLD
	} state_t;

endpackage

// File: design/crtl_if.sv
// valid/ready channels of the code range table lookup unit
// depends on crtl_pkg for field widths
`timescale 1ns / 1ps

interface crtl_in_if import crtl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CODE_W-1:0]   range_first;
	logic [CODE_W-1:0]   range_last;
	logic [BASE_W-1:0]   range_base;
	logic [CODE_W-1:0]   code_point;

	modport source (
		output valid, action, range_first, range_last, range_base, code_point,
		input  ready
	);
	modport sink (
		input  valid, action, range_first, range_last, range_base, code_point,
		output ready
	);
endinterface

interface crtl_out_if import crtl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [GLYPH_W-1:0]  glyph_index;

	modport source (
		output valid, status, glyph_index,
		input  ready
	);
	modport sink (
		input  valid, status, glyph_index,
		output ready
	);
endinterface

// File: design/code_range_table_lookup_unit.sv
// clear and append: the result is registered, then moved into the output register once that is free
// lookup: one binary search probe per cycle (up to ceil(log2(n+1)) probes, 13 for 4096 entries),
// then a miss goes to hold, a hit via finish; the probe loop is bounded by the bound memory read port
// one item in flight; the output register lets the next item in while a result waits
// reset (async, active low) empties the table; the memories themselves are never swept
`timescale 1ns / 1ps

module code_range_table_lookup_unit import crtl_pkg::*; #(
	parameter int unsigned MAX_RANGES = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	crtl_in_if.sink  req,
	crtl_out_if.source rsp
);

	// entry count must hold MAX_RANGES itself, the index only up to MAX_RANGES-1
	localparam int unsigned CW = $clog2(MAX_RANGES + 1);
	localparam int unsigned IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

	// table storage: {first, last} and base glyph index, registered read
	logic [BOUND_W-1:0] bnd_mem [MAX_RANGES];
	logic [BASE_W-1:0]  base_mem [MAX_RANGES];
	logic [BOUND_W-1:0] bnd_rd_q;
	logic [BASE_W-1:0]  base_rd_q;

	// control state
	state_t          state_q, state_n;
	logic [CW-1:0]   cnt_q, cnt_n;
	logic            out_valid_q, out_valid_n;

	// search and result payload
	logic [IW-1:0]       lo_q, lo_n;
	logic [IW-1:0]       hi_q, hi_n;
	logic [IW-1:0]       mid_q, mid_n;
	logic [CODE_W-1:0]   code_q, code_n;
	logic [CODE_W-1:0]   off_q, off_n;
	logic [STATUS_W-1:0] res_status_q, res_status_n;
	logic [GLYPH_W-1:0]  res_glyph_q, res_glyph_n;
	logic [STATUS_W-1:0] out_status_q, out_status_n;
	logic [GLYPH_W-1:0]  out_glyph_q, out_glyph_n;

	// memory port controls
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;

	// datapath helpers
	logic              take;
	logic              out_free;
	logic              full;
	logic [CW-1:0]     cnt_m1;
	logic [CODE_W-1:0] ent_first;
	logic [CODE_W-1:0] ent_last;
	logic              go_left;
	logic              go_right;
	logic [IW-1:0]     span_l, span_r;
	logic [IW-1:0]     mid_l, mid_r;

	assign take     = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign full     = (cnt_q == CW'(MAX_RANGES));
	assign cnt_m1   = cnt_q - CW'(1);

	// compare the probed entry against the code
	assign ent_first = bnd_rd_q[BOUND_W-1:CODE_W];
	assign ent_last  = bnd_rd_q[CODE_W-1:0];
	assign go_left   = (code_q < ent_first);
	assign go_right  = (code_q > ent_last);

	// both candidate midpoints are formed alongside the compare, the compare picks one
	// left half: lo .. mid-1, right half: mid+1 .. hi
	assign span_l = mid_q - lo_q - IW'(1);
	assign mid_l  = lo_q + (span_l >> 1);
	assign span_r = hi_q - mid_q - IW'(1);
	assign mid_r  = mid_q + IW'(1) + (span_r >> 1);

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.glyph_index = out_glyph_q;

	// next state and datapath control
	always_comb begin
		state_n      = state_q;
		cnt_n        = cnt_q;
		out_valid_n  = out_valid_q;
		lo_n         = lo_q;
		hi_n         = hi_q;
		mid_n        = mid_q;
		code_n       = code_q;
		off_n        = off_q;
		res_status_n = res_status_q;
		res_glyph_n  = res_glyph_q;
		out_status_n = out_status_q;
		out_glyph_n  = out_glyph_q;
		rd_en        = 1'b0;
		rd_addr      = mid_q;
		wr_en        = 1'b0;

		// a taken result frees the output register
		if (rsp.ready) begin
			out_valid_n = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					res_status_n = STAT_OK;
					res_glyph_n  = '0;
					state_n      = ST_HOLD;
					unique case (req.action)
						ACT_CLEAR: begin
							cnt_n = '0;
						end
						ACT_APPEND: begin
							if (full) begin
								res_status_n = STAT_FULL;
							end else begin
								wr_en = 1'b1;
								cnt_n = cnt_q + CW'(1);
							end
						end
						ACT_LOOKUP: begin
							code_n = req.code_point;
							if (cnt_q == '0) begin
								// empty table never hits
								res_status_n = STAT_MISS;
							end else begin
								// first probe at the middle of 0 .. count-1
								lo_n    = '0;
								hi_n    = cnt_m1[IW-1:0];
								mid_n   = cnt_m1[IW-1:0] >> 1;
								rd_en   = 1'b1;
								rd_addr = cnt_m1[IW-1:0] >> 1;
								state_n = ST_SEARCH;
							end
						end
						default: begin
							// unused action code: no state change, plain done
						end
					endcase
				end
			end

			ST_SEARCH: begin
				// bnd_rd_q and base_rd_q hold the entry at mid_q
				priority if (go_left) begin
					if (mid_q == lo_q) begin
						res_status_n = STAT_MISS;
						res_glyph_n  = '0;
						state_n      = ST_HOLD;
					end else begin
						hi_n    = mid_q - IW'(1);
						mid_n   = mid_l;
						rd_en   = 1'b1;
						rd_addr = mid_l;
					end
				end else if (go_right) begin
					if (mid_q == hi_q) begin
						res_status_n = STAT_MISS;
						res_glyph_n  = '0;
						state_n      = ST_HOLD;
					end else begin
						lo_n    = mid_q + IW'(1);
						mid_n   = mid_r;
						rd_en   = 1'b1;
						rd_addr = mid_r;
					end
				end else begin
					// hit: keep the offset, the base stays in base_rd_q
					off_n   = code_q - ent_first;
					state_n = ST_FINISH;
				end
			end

			ST_FINISH: begin
				res_status_n = STAT_OK;
				res_glyph_n  = GLYPH_W'(base_rd_q) + GLYPH_W'(off_q);
				state_n      = ST_HOLD;
			end

			ST_HOLD: begin
				// move the result on once the output register is free
				if (out_free) begin
					out_valid_n  = 1'b1;
					out_status_n = res_status_q;
					out_glyph_n  = res_glyph_q;
					state_n      = ST_IDLE;
				end
			end

			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// table memories: append writes at the current count, search reads one entry a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			bnd_mem[cnt_q[IW-1:0]]  <= {req.range_first, req.range_last};
			base_mem[cnt_q[IW-1:0]] <= req.range_base;
		end
		if (rd_en) begin
			bnd_rd_q  <= bnd_mem[rd_addr];
			base_rd_q <= base_mem[rd_addr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			cnt_q       <= cnt_n;
			out_valid_q <= out_valid_n;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		lo_q         <= lo_n;
		hi_q         <= hi_n;
		mid_q        <= mid_n;
		code_q       <= code_n;
		off_q        <= off_n;
		res_status_q <= res_status_n;
		res_glyph_q  <= res_glyph_n;
		out_status_q <= out_status_n;
		out_glyph_q  <= out_glyph_n;
	end

`ifndef SYNTHESIS
	// entry count never runs past the table size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_RANGES))
		else $error("entry count above table size");

	// probe stays inside the current search window
	a_mid_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> (lo_q <= mid_q) && (mid_q <= hi_q) && (hi_q < cnt_q))
		else $error("search probe outside window");

	// a taken item always leaves idle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q != ST_IDLE)
		else $error("item taken but unit stayed idle");

	// the result is only handed over into a free output register
	a_hold_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD && !out_free |=> state_q == ST_HOLD)
		else $error("result left hold while output busy");
`endif

endmodule

// File: tb/tb_code_range_table_lookup_unit.sv
// self-checking testbench of the code range table lookup unit
// needs crtl_pkg, crtl_in_if / crtl_out_if and code_range_table_lookup_unit
`timescale 1ns / 1ps

module tb_code_range_table_lookup_unit;
	import crtl_pkg::*;

	localparam int MAX_RANGES  = 4096;
	localparam int DEEP_RANGES = 300;
	localparam int IDLE_PCT    = 35;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 50;
	localparam int RANDOM_CMDS = 1250;

	// the action code that the block leaves unused
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	// one command to the table, plus a flag that holds it back until the unit drains
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [CODE_W-1:0]   first;
		logic [CODE_W-1:0]   last;
		logic [BASE_W-1:0]   base;
		logic [CODE_W-1:0]   code;
		logic                hold;
	} table_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [GLYPH_W-1:0]  glyph;
	} table_answer_t;

	logic clk;
	logic arst_n;

	crtl_in_if  req_ch ();
	crtl_out_if rsp_ch ();

	code_range_table_lookup_unit #(
		.MAX_RANGES (MAX_RANGES)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// mirror of the range table, updated in acceptance order
	logic [CODE_W-1:0] tbl_first [MAX_RANGES];
	logic [CODE_W-1:0] tbl_last  [MAX_RANGES];
	logic [BASE_W-1:0] tbl_base  [MAX_RANGES];
	int                tbl_count;

	table_cmd_t    cmd_queue[$];       // commands not yet offered to the unit
	table_answer_t lookup_answers[$];  // answers owed by the unit, oldest first
	table_cmd_t    drv_cmd;            // command currently on the request channel

	// ranges the generator has appended since its last clear, used to aim lookups
	logic [CODE_W-1:0] gen_first[$];
	logic [CODE_W-1:0] gen_last[$];

	int planned_cmds;
	int fill_cmds;
	int accepted_cmds;
	int answers_seen;
	int mismatches;
	int stall_cycles;
	int n_hits, n_misses, n_rejects, n_ignored, peak_count;

	// no idling at all over a stretch of a few hundred accepted items
	wire calm = (accepted_cmds >= 400) && (accepted_cmds < 800);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one command to the mirror and work out the answer the unit owes
	function automatic table_answer_t apply_table_cmd(input table_cmd_t cmd);
		table_answer_t ans;
		int            lo, hi, mid;
		bit            found;
		ans.status = STAT_OK;
		ans.glyph  = '0;
		case (cmd.action)
			ACT_CLEAR: begin
				tbl_count = 0;
			end
			ACT_APPEND: begin
				if (tbl_count >= MAX_RANGES) begin
					ans.status = STAT_FULL;
					n_rejects++;
				end else begin
					tbl_first[tbl_count] = cmd.first;
					tbl_last[tbl_count]  = cmd.last;
					tbl_base[tbl_count]  = cmd.base;
					tbl_count++;
					if (tbl_count > peak_count)
						peak_count = tbl_count;
				end
			end
			ACT_LOOKUP: begin
				// plain binary search; unordered or inverted entries just steer it
				lo    = 0;
				hi    = tbl_count - 1;
				found = 1'b0;
				while (lo <= hi && !found) begin
					mid = lo + (hi - lo) / 2;
					if (cmd.code < tbl_first[mid])
						hi = mid - 1;
					else if (cmd.code > tbl_last[mid])
						lo = mid + 1;
					else begin
						found     = 1'b1;
						ans.glyph = GLYPH_W'(tbl_base[mid]) + GLYPH_W'(cmd.code - tbl_first[mid]);
					end
				end
				if (found)
					n_hits++;
				else begin
					ans.status = STAT_MISS;
					n_misses++;
				end
			end
			default: begin
				n_ignored++;
			end
		endcase
		return ans;
	endfunction

	task automatic add_cmd(input logic [ACTION_W-1:0] act, input logic [CODE_W-1:0] f,
			input logic [CODE_W-1:0] l, input logic [BASE_W-1:0] b,
			input logic [CODE_W-1:0] c, input bit hold);
		table_cmd_t cmd;
		cmd = '{action: act, first: f, last: l, base: b, code: c, hold: hold};
		cmd_queue = {cmd_queue, cmd};
		if (act != ACT_UNUSED)
			planned_cmds++;
		if (act == ACT_CLEAR) begin
			gen_first.delete();
			gen_last.delete();
		end else if (act == ACT_APPEND) begin
			gen_first = {gen_first, f};
			gen_last  = {gen_last, l};
		end
	endtask

	// bases near the top of 24 bits push the glyph index into bit 24
	function automatic logic [BASE_W-1:0] pick_base();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return BASE_W'($urandom_range(24'hFFFFFF, 24'hFFF000));
		else if (r < 15)
			return '0;
		return BASE_W'($urandom);
	endfunction

	// lookups aim inside known ranges, at their edges, at the extremes, or anywhere
	function automatic logic [CODE_W-1:0] pick_code();
		int                r, k;
		logic [CODE_W-1:0] c;
		r = $urandom_range(99);
		if (gen_first.size() == 0 || r >= 75)
			return CODE_W'($urandom);
		if (r >= 68)
			return ($urandom_range(1) != 0) ? '1 : '0;
		k = $urandom_range(gen_first.size() - 1);
		if (r < 40)
			return CODE_W'($urandom_range(gen_last[k], gen_first[k]));
		case ($urandom_range(3))
			0:       c = gen_first[k] - 1;
			1:       c = gen_first[k];
			2:       c = gen_last[k];
			default: c = gen_last[k] + 1;
		endcase
		return c;
	endfunction

	// ascending, non-overlapping ranges, each in its own slot of the code space;
	// a quirky table now and then gets an inverted or misplaced entry
	task automatic gen_table(input int n, input bit quirky);
		int unsigned       span, lo, w;
		logic [CODE_W-1:0] f, l, t;
		if (n == 0)
			return;
		span = (1 << CODE_W) / n;
		for (int i = 0; i < n; i++) begin
			lo = i * span;
			w  = ($urandom_range(3) == 0) ? 0 : $urandom_range(span / 2 - 1);
			f  = CODE_W'(lo + $urandom_range(span / 2));
			l  = CODE_W'(f + w);
			if (quirky) begin
				case ($urandom_range(19))
					0: begin
						t = f;
						f = l;
						l = t;
					end
					1: begin
						f = CODE_W'($urandom);
						l = CODE_W'($urandom);
					end
					default: ;
				endcase
			end
			add_cmd(ACT_APPEND, f, l, pick_base(), CODE_W'($urandom), 1'b0);
		end
	endtask

	// lookups with a little noise: unused action codes and stray appends
	task automatic gen_lookups(input int k);
		int r;
		for (int i = 0; i < k; i++) begin
			r = $urandom_range(99);
			if (r < 4)
				add_cmd(ACT_UNUSED, CODE_W'($urandom), CODE_W'($urandom), BASE_W'($urandom),
					CODE_W'($urandom), 1'b0);
			else if (r < 8)
				add_cmd(ACT_APPEND, CODE_W'($urandom), CODE_W'($urandom), pick_base(),
					CODE_W'($urandom), 1'b0);
			else
				add_cmd(ACT_LOOKUP, CODE_W'($urandom), CODE_W'($urandom), BASE_W'($urandom),
					pick_code(), 1'b0);
		end
	endtask

	// one random episode: usually a fresh table, sometimes more entries on top of the old one
	task automatic gen_episode();
		int n;
		bit hold;
		n    = ($urandom_range(9) == 0) ? $urandom_range(300, 25) : $urandom_range(24);
		hold = ($urandom_range(9) == 0);
		if ($urandom_range(99) < 85)
			add_cmd(ACT_CLEAR, CODE_W'($urandom), CODE_W'($urandom), BASE_W'($urandom),
				CODE_W'($urandom), hold);
		else
			add_cmd(ACT_LOOKUP, '0, '0, '0, pick_code(), hold);
		gen_table(n, $urandom_range(3) == 0);
		gen_lookups($urandom_range(30, 4));
	endtask

	// request side: keeps valid up until the item is taken, idles at random between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.action      <= '0;
			req_ch.range_first <= '0;
			req_ch.range_last  <= '0;
			req_ch.range_base  <= '0;
			req_ch.code_point  <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				lookup_answers = {lookup_answers, apply_table_cmd(drv_cmd)};
				accepted_cmds <= accepted_cmds + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				// a held item waits until every owed answer has come back
				if (cmd_queue.size() != 0 && !(cmd_queue[0].hold && lookup_answers.size() != 0)
						&& (calm || $urandom_range(99) >= IDLE_PCT)) begin
					drv_cmd = cmd_queue.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.action      <= drv_cmd.action;
					req_ch.range_first <= drv_cmd.first;
					req_ch.range_last  <= drv_cmd.last;
					req_ch.range_base  <= drv_cmd.base;
					req_ch.code_point  <= drv_cmd.code;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response side: random back-pressure, each taken item checked against the oldest answer
	always @(posedge clk or negedge arst_n) begin
		table_answer_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				answers_seen++;
				if (lookup_answers.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result item status %0d glyph %0h", $time,
						rsp_ch.status, rsp_ch.glyph_index);
				end else begin
					want = lookup_answers.pop_front();
					if (rsp_ch.status !== want.status) begin
						mismatches++;
						$display("%0t: status mismatch, expected %0d got %0d", $time,
							want.status, rsp_ch.status);
					end
					if (rsp_ch.glyph_index !== want.glyph) begin
						mismatches++;
						$display("%0t: glyph_index mismatch, expected %0h got %0h", $time,
							want.glyph, rsp_ch.glyph_index);
					end
				end
			end
			rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog: too long without any item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("tb_code_range_table_lookup_unit: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int fill_start;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.action       = '0;
		req_ch.range_first  = '0;
		req_ch.range_last   = '0;
		req_ch.range_base   = '0;
		req_ch.code_point   = '0;
		rsp_ch.ready        = 1'b0;
		tbl_count           = 0;
		planned_cmds        = 0;
		fill_cmds           = 0;
		accepted_cmds       = 0;
		answers_seen        = 0;
		mismatches          = 0;
		stall_cycles        = 0;
		n_hits              = 0;
		n_misses            = 0;
		n_rejects           = 0;
		n_ignored           = 0;
		peak_count          = 0;

		// directed: empty table, unused code, field extremes, glyph carry into bit 24,
		// inverted entry, out-of-order entry, clear with all-ones fields, full-span range
		add_cmd(ACT_LOOKUP, '0, '0, '0, '0, 1'b0);
		add_cmd(ACT_LOOKUP, '1, '1, '1, '1, 1'b0);
		add_cmd(ACT_UNUSED, '1, '1, '1, '1, 1'b0);
		add_cmd(ACT_APPEND, '0, '0, '1, '0, 1'b0);
		add_cmd(ACT_APPEND, 21'd1, 21'd100, '0, '0, 1'b0);
		add_cmd(ACT_APPEND, 21'h1FFFF0, '1, '1, '1, 1'b0);
		add_cmd(ACT_LOOKUP, '0, '0, '0, '0, 1'b0);
		add_cmd(ACT_LOOKUP, '0, '0, '0, 21'd1, 1'b0);
		add_cmd(ACT_LOOKUP, '0, '0, '0, 21'd100, 1'b0);
		add_cmd(ACT_LOOKUP, '0, '0, '0, 21'd101, 1'b0);
		add_cmd(ACT_LOOKUP, '0, '0, '0, '1, 1'b0);
		add_cmd(ACT_LOOKUP, '0, '0, '0, 21'h1FFFEF, 1'b0);
		add_cmd(ACT_APPEND, 21'd300, 21'd200, 24'd5, '0, 1'b0);
		add_cmd(ACT_LOOKUP, '0, '0, '0, 21'd250, 1'b0);
		add_cmd(ACT_APPEND, 21'd50, 21'd60, 24'd7, '0, 1'b0);
		add_cmd(ACT_LOOKUP, '0, '0, '0, 21'd55, 1'b0);
		add_cmd(ACT_UNUSED, '0, '0, '0, '0, 1'b0);
		add_cmd(ACT_LOOKUP, '0, '0, '0, 21'd100, 1'b0);
		add_cmd(ACT_CLEAR, '1, '1, '1, '1, 1'b0);
		add_cmd(ACT_LOOKUP, '0, '0, '0, 21'd1, 1'b0);
		add_cmd(ACT_APPEND, '0, '1, '1, '0, 1'b0);
		add_cmd(ACT_LOOKUP, '0, '0, '0, '1, 1'b0);

		// first half of the random episodes
		while (planned_cmds < RANDOM_CMDS / 2)
			gen_episode();

		// a deep table for long searches; the sender waits for the unit to drain first
		fill_start = planned_cmds;
		add_cmd(ACT_CLEAR, '0, '0, '0, '0, 1'b1);
		gen_table(DEEP_RANGES, 1'b0);
		for (int i = 0; i < 40; i++)
			add_cmd(ACT_LOOKUP, '0, '0, '0, pick_code(), 1'b0);
		fill_cmds = planned_cmds - fill_start;

		// rest of the random episodes
		while (planned_cmds < RANDOM_CMDS)
			gen_episode();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || req_ch.valid || lookup_answers.size() != 0)
			@(posedge clk);
		// let any stray result surface before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d items (%0d of them in the deep table), %0d results checked",
			accepted_cmds, fill_cmds, answers_seen);
		$display("lookups: %0d hits, %0d misses; %0d full-table rejects, %0d unused codes, %0s %0d",
			n_hits, n_misses, n_rejects, n_ignored, "peak entries", peak_count);
		if (mismatches == 0 && lookup_answers.size() == 0) begin
			$display("tb_code_range_table_lookup_unit: PASS");
		end else begin
			$display("tb_code_range_table_lookup_unit: FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/crtl_pkg.sv
design/crtl_if.sv
design/code_range_table_lookup_unit.sv
tb/tb_code_range_table_lookup_unit.sv
